@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; compiled out when NO_ASSERTIONS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/tcw_pkg.sv @@
// Shared types, widths and character codes for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 64;
  localparam int ROWS_DEF    = 31;

  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int CELL_W    = 32;
  localparam int COL_OUT_W = 6;
  localparam int ROW_OUT_W = 5;

  // control bytes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UP    = 8'h90;
  localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h91;
  localparam logic [CHAR_W-1:0] CH_DOWN  = 8'h92;
  localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h93;
  localparam logic [CHAR_W-1:0] CH_HOME  = 8'h94;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h99;

  typedef struct packed {
    logic               mode;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_value;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [ROW_OUT_W-1:0] cursor_row;
  } tcw_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_CP_RD,
    ST_CP_WR,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

endpackage

`default_nettype wire

@@ rtl/tcw_if.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface tcw_req_if;
  logic              valid;
  logic              ready;
  tcw_pkg::tcw_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tcw_rsp_if;
  logic              valid;
  logic              ready;
  tcw_pkg::tcw_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/text_console_char_writer.sv @@
// Top level of the text console: cursor sequencer around the screen RAM.
// Usage: requests arrive on req (valid/ready). mode 0 feeds one character or
// control byte; mode 1 reads the cell at cell_index (zero when out of range).
// Every request gives exactly one result on rsp: the cell read (zero in mode 0)
// and the cursor position after the request. The attribute register is written
// through attr_we/attr_wdata by the user only while the block is idle; not enforced.
// Work per request: cursor moves, CR and LF without scroll write no cell;
// a printable byte writes one cell and a tab writes four; a cell read uses
// the registered RAM read; delete/backspace copy the rest of the line left
// and blank the last column; clear screen blanks every cell; a scroll copies
// the rows up and blanks the last row on top of its request.
// All of these are set by the single RAM write port, one cell per cycle,
// and a copy that reads and then writes each cell. req.ready is high
// only while the sequencer is idle, so one request is in flight at a time.
// Reset: synchronous, active high. Afterwards a clearing pass writes zero to
// all COLUMNS*ROWS cells (1984 cells by default) with req.ready low;
// attribute writes are taken meanwhile. Cursor and attribute reset to zero.
// Stall: the result sits in an output register; a request is taken while an
// old result waits, and its own result holds in the final state until rsp has room.
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  tcw_req_if.sink                        req,
  tcw_rsp_if.source                      rsp,
  input  wire logic                      attr_we,
  input  wire logic [tcw_pkg::CELL_W-1:0] attr_wdata
);

`include "assert_macros.svh"

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int CELL_W    = tcw_pkg::CELL_W;
  localparam int COL_OUT_W = tcw_pkg::COL_OUT_W;
  localparam int ROW_OUT_W = tcw_pkg::ROW_OUT_W;

  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);

  // sequencer registers
  tcw_pkg::tcw_state_t state, state_next;
  logic                init, init_next;
  logic [CW-1:0]       col, col_next;
  logic [RW-1:0]       row, row_next;
  logic [AW-1:0]       ptr, ptr_next;
  logic [AW-1:0]       copy_last, copy_last_next;
  logic [AW-1:0]       fill_last, fill_last_next;
  logic                off_row, off_row_next;
  logic [2:0]          tab_left, tab_left_next;
  logic [tcw_pkg::CHAR_W-1:0] put_val, put_val_next;
  logic                in_range, in_range_next;
  logic [CELL_W-1:0]   res_cell, res_cell_next;
  logic [CELL_W-1:0]   attribute;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [AW-1:0]     row_base;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     src_addr;
  logic [CELL_W-1:0] blank;
  logic              load_rsp;
  logic              start_scroll;
  logic              start_del;
  logic              start_clear;
  logic [CW-1:0]     del_col;

  assign row_base = AW'(row) * AW'(COLUMNS);
  assign cur_addr = row_base + AW'(col);
  // copy source: next cell for line shifts, next row for scroll
  assign src_addr = ptr + (off_row ? AW'(COLUMNS) : AW'(1));
  assign blank    = attribute | CELL_W'(tcw_pkg::CH_SPACE);
  assign req.ready = (state == tcw_pkg::ST_IDLE);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= '0;
    end else if (attr_we) begin
      attribute <= attr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_FILL;
      init      <= 1'b1;
      col       <= '0;
      row       <= '0;
      ptr       <= '0;
      fill_last <= ADDR_LAST;
      tab_left  <= '0;
    end else begin
      state     <= state_next;
      init      <= init_next;
      col       <= col_next;
      row       <= row_next;
      ptr       <= ptr_next;
      fill_last <= fill_last_next;
      tab_left  <= tab_left_next;
    end
  end

  always_ff @(posedge clk) begin
    copy_last <= copy_last_next;
    off_row   <= off_row_next;
    put_val   <= put_val_next;
    in_range  <= in_range_next;
    res_cell  <= res_cell_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.payload.cell_value    <= res_cell;
      rsp.payload.cursor_column <= COL_OUT_W'(col);
      rsp.payload.cursor_row    <= ROW_OUT_W'(row);
    end
  end

  always_comb begin
    state_next     = state;
    init_next      = init;
    col_next       = col;
    row_next       = row;
    ptr_next       = ptr;
    copy_last_next = copy_last;
    fill_last_next = fill_last;
    off_row_next   = off_row;
    tab_left_next  = tab_left;
    put_val_next   = put_val;
    in_range_next  = in_range;
    res_cell_next  = res_cell;
    ram_we         = 1'b0;
    ram_waddr      = ptr;
    ram_wdata      = blank;
    ram_raddr      = src_addr;
    load_rsp       = 1'b0;
    start_scroll   = 1'b0;
    start_del      = 1'b0;
    start_clear    = 1'b0;
    del_col        = col;

    unique case (state)
      tcw_pkg::ST_IDLE: begin
        ram_raddr = AW'(req.payload.cell_index);
        if (req.valid) begin
          res_cell_next = '0;
          tab_left_next = '0;
          state_next    = tcw_pkg::ST_DONE;
          if (req.payload.mode) begin
            in_range_next = (32'(req.payload.cell_index) < 32'(CELLS));
            state_next    = tcw_pkg::ST_READ;
          end else begin
            unique case (req.payload.char_code)
              tcw_pkg::CH_CR: begin
                col_next = '0;
              end
              tcw_pkg::CH_LF: begin
                if (row != ROW_LAST) begin
                  row_next = row + 1'b1;
                end else begin
                  start_scroll = 1'b1;
                end
              end
              tcw_pkg::CH_RIGHT: begin
                if (col != COL_LAST) begin
                  col_next = col + 1'b1;
                end
              end
              tcw_pkg::CH_UP: begin
                if (row != '0) begin
                  row_next = row - 1'b1;
                end
              end
              tcw_pkg::CH_LEFT: begin
                if (col != '0) begin
                  col_next = col - 1'b1;
                end
              end
              tcw_pkg::CH_DOWN: begin
                if (row != ROW_LAST) begin
                  row_next = row + 1'b1;
                end
              end
              tcw_pkg::CH_HOME: begin
                if (col == '0) begin
                  row_next = '0;
                end
                col_next = '0;
              end
              tcw_pkg::CH_DEL: begin
                start_del = 1'b1;
              end
              tcw_pkg::CH_BS: begin
                if (col != '0) begin
                  col_next  = col - 1'b1;
                  del_col   = col - 1'b1;
                  start_del = 1'b1;
                end
              end
              tcw_pkg::CH_FF: begin
                col_next    = '0;
                row_next    = '0;
                start_clear = 1'b1;
              end
              tcw_pkg::CH_TAB: begin
                tab_left_next = 3'd4;
                put_val_next  = tcw_pkg::CH_SPACE;
                state_next    = tcw_pkg::ST_PUT;
              end
              default: begin
                tab_left_next = 3'd1;
                put_val_next  = req.payload.char_code;
                state_next    = tcw_pkg::ST_PUT;
              end
            endcase
          end
        end
      end

      tcw_pkg::ST_READ: begin
        res_cell_next = in_range ? ram_rdata : '0;
        state_next    = tcw_pkg::ST_DONE;
      end

      tcw_pkg::ST_PUT: begin
        ram_we        = 1'b1;
        ram_waddr     = cur_addr;
        ram_wdata     = attribute | CELL_W'(put_val);
        tab_left_next = tab_left - 1'b1;
        state_next    = (tab_left == 3'd1) ? tcw_pkg::ST_DONE : tcw_pkg::ST_PUT;
        if (col == COL_LAST) begin
          col_next = '0;
          if (row != ROW_LAST) begin
            row_next = row + 1'b1;
          end else begin
            start_scroll = 1'b1;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end

      tcw_pkg::ST_CP_RD: begin
        state_next = tcw_pkg::ST_CP_WR;
      end

      tcw_pkg::ST_CP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_next  = ptr + 1'b1;
        // the fill always starts right after the last copied cell
        state_next = (ptr == copy_last) ? tcw_pkg::ST_FILL : tcw_pkg::ST_CP_RD;
      end

      tcw_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = init ? '0 : blank;
        ptr_next  = ptr + 1'b1;
        if (ptr == fill_last) begin
          init_next = 1'b0;
          if (init) begin
            state_next = tcw_pkg::ST_IDLE;
          end else if (tab_left != '0) begin
            state_next = tcw_pkg::ST_PUT;
          end else begin
            state_next = tcw_pkg::ST_DONE;
          end
        end
      end

      tcw_pkg::ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase

    // scroll: copy rows up, then blank the last row
    if (start_scroll) begin
      ptr_next       = '0;
      copy_last_next = AW'(CELLS - COLUMNS - 1);
      fill_last_next = ADDR_LAST;
      off_row_next   = 1'b1;
      state_next     = tcw_pkg::ST_CP_RD;
    end

    // line shift left from del_col, blank in the last column
    if (start_del) begin
      copy_last_next = row_base + AW'(COLUMNS - 2);
      fill_last_next = row_base + AW'(COLUMNS - 1);
      off_row_next   = 1'b0;
      if (del_col == COL_LAST) begin
        ptr_next   = row_base + AW'(COLUMNS - 1);
        state_next = tcw_pkg::ST_FILL;
      end else begin
        ptr_next   = row_base + AW'(del_col);
        state_next = tcw_pkg::ST_CP_RD;
      end
    end

    if (start_clear) begin
      ptr_next       = '0;
      fill_last_next = ADDR_LAST;
      state_next     = tcw_pkg::ST_FILL;
    end
  end

  `ASSERT_ALWAYS(a_cursor_in_range, clk, rst, col <= COL_LAST && row <= ROW_LAST)
  `ASSERT_IMPLY(a_write_in_range, clk, rst, ram_we, ram_waddr <= ADDR_LAST)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `ASSERT_IMPLY(a_no_result_in_init, clk, rst, init, !rsp.valid && !req.ready)

endmodule

`default_nettype wire
